// File: rtl/frustum_cull_test_defines.svh
// assertion macros for the frustum cull test block
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

// checked only while out of reset
`define FCT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define FCT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: rtl/fct_pkg.sv
// shared types and constants for the frustum cull test block
package fct_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned RadiusW  = 15;
  localparam int unsigned ProdW    = 2 * CoordW;
  localparam int unsigned ThrW     = CoordW + 1;
  localparam int unsigned AlignSh  = 14;
  localparam int unsigned DistW    = ProdW + 3;
  localparam int unsigned NumPlanes = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    KindPoint  = 2'd0,
    KindBox    = 2'd1,
    KindSphere = 2'd2
  } kind_e;

  localparam logic [CfgIdxW-1:0] RegNear   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFar    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTop    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRight  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBottom = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLeft   = 3'd5;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t offset;
    coord_t nz;
    coord_t ny;
    coord_t nx;
  } plane_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec_t;

  typedef struct packed {
    logic is_box;
    logic is_sphere;
  } mode_t;

  typedef struct packed {
    logic                 pad;
    logic [RadiusW-1:0]   sphere_radius;
    coord_t               second_z;
    coord_t               second_y;
    coord_t               second_x;
    coord_t               first_z;
    coord_t               first_y;
    coord_t               first_x;
  } in_data_t;

endpackage

// File: rtl/fct_plane.sv
// one frustum plane: product stage and distance compare
module fct_plane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  fct_pkg::mode_t                mode_i,
  input  fct_pkg::vec_t                 lo_i,
  input  fct_pkg::vec_t                 hi_i,
  input  logic [fct_pkg::RadiusW-1:0]   radius_i,
  input  fct_pkg::plane_t               plane_i,
  output logic                          reject_o
);
  import fct_pkg::*;

  // the smaller of low*n and high*n comes from min(low, high) when n >= 0
  function automatic coord_t pick(coord_t a, coord_t b, coord_t n, logic box);
    coord_t res;
    res = a;
    if (box) begin
      if (n[CoordW-1]) begin
        res = (a > b) ? a : b;
      end else begin
        res = (a < b) ? a : b;
      end
    end
    return res;
  endfunction

  coord_t sel_x, sel_y, sel_z;
  logic signed [ProdW-1:0] prod_x_d, prod_y_d, prod_z_d;
  logic signed [ProdW-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic [RadiusW-1:0] rad_sel;
  logic signed [ThrW-1:0] thr_d, thr_q;
  logic signed [DistW-1:0] sum, thr_ext;

  assign sel_x = pick(lo_i.x, hi_i.x, plane_i.nx, mode_i.is_box);
  assign sel_y = pick(lo_i.y, hi_i.y, plane_i.ny, mode_i.is_box);
  assign sel_z = pick(lo_i.z, hi_i.z, plane_i.nz, mode_i.is_box);

  assign prod_x_d = ProdW'(sel_x) * ProdW'(plane_i.nx);
  assign prod_y_d = ProdW'(sel_y) * ProdW'(plane_i.ny);
  assign prod_z_d = ProdW'(sel_z) * ProdW'(plane_i.nz);

  assign rad_sel = mode_i.is_sphere ? radius_i : '0;
  assign thr_d   = $signed({plane_i.offset[CoordW-1], plane_i.offset})
                 + $signed({2'b00, rad_sel});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
      thr_q    <= thr_d;
    end
  end

  assign sum     = DistW'(prod_x_q) + DistW'(prod_y_q) + DistW'(prod_z_q);
  assign thr_ext = DistW'($signed({thr_q, {AlignSh{1'b0}}}));
  assign reject_o = (sum > thr_ext);

endmodule

// File: rtl/frustum_cull_test.sv
// Frustum cull test: takes one point, axis-aligned box or sphere per request
// and tests it against six planes (near, far, top, right, bottom, left) held
// in 64-bit configuration registers written through cfg_we_i/cfg_idx_i.
// One request is accepted per cycle unless back pressure fills the pipeline; the
// result is offered once the request has moved through the stages below.
// The request passes an input register, a product stage of eighteen 16x16
// multipliers (one per plane and axis) and a sum/compare stage feeding the
// output register. Back pressure on the result side stalls the whole
// pipeline, which still holds three requests before the input side stalls.
// Request type 3 is treated as a point; box corners may come in any order.
module frustum_cull_test (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fct_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fct_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, sphere_radius, pad
  input  logic [fct_pkg::InDataW-1:0]   s_axis_tdata,
  // req_type
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // visible, pad
  output logic [fct_pkg::OutDataW-1:0]  m_axis_tdata
);
  import fct_pkg::*;

  plane_t planes_q [NumPlanes];

  in_data_t req;
  mode_t    mode_d, mode0_q;
  vec_t     lo0_q, hi0_q;
  logic [RadiusW-1:0] rad0_q;
  logic v0_q, v1_q, v2_q, vis_q;
  logic out_free, s1_free, s0_free, ld1, ld2;
  logic [NumPlanes-1:0] reject;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumPlanes; k++) begin
        planes_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegNear:   planes_q[0] <= plane_t'(cfg_data_i);
        RegFar:    planes_q[1] <= plane_t'(cfg_data_i);
        RegTop:    planes_q[2] <= plane_t'(cfg_data_i);
        RegRight:  planes_q[3] <= plane_t'(cfg_data_i);
        RegBottom: planes_q[4] <= plane_t'(cfg_data_i);
        RegLeft:   planes_q[5] <= plane_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // stage handshake
  assign out_free      = !v2_q || m_axis_tready;
  assign s1_free       = !v1_q || out_free;
  assign s0_free       = !v0_q || s1_free;
  assign ld1           = v0_q && s1_free;
  assign ld2           = v1_q && out_free;
  assign s_axis_tready = s0_free;

  assign req              = in_data_t'(s_axis_tdata);
  assign mode_d.is_box    = (s_axis_tuser == KindBox);
  assign mode_d.is_sphere = (s_axis_tuser == KindSphere);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s0_free) begin
        v0_q <= s_axis_tvalid;
      end
      if (s1_free) begin
        v1_q <= v0_q;
      end
      if (out_free) begin
        v2_q <= v1_q;
      end
    end
  end

  // request register
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s0_free) begin
      mode0_q <= mode_d;
      lo0_q   <= '{x: req.first_x, y: req.first_y, z: req.first_z};
      hi0_q   <= '{x: req.second_x, y: req.second_y, z: req.second_z};
      rad0_q  <= req.sphere_radius;
    end
  end

  for (genvar g = 0; g < NumPlanes; g++) begin : g_plane
    fct_plane u_plane (
      .clk_i    (clk_i),
      .en_i     (ld1),
      .mode_i   (mode0_q),
      .lo_i     (lo0_q),
      .hi_i     (hi0_q),
      .radius_i (rad0_q),
      .plane_i  (planes_q[g]),
      .reject_o (reject[g])
    );
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ld2) begin
      vis_q <= ~|reject;
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {{(OutDataW-1){1'b0}}, vis_q};

endmodule

// File: rtl/fct_checker.sv
// port-level checks for the frustum cull test block
`include "frustum_cull_test_defines.svh"

module fct_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [fct_pkg::OutDataW-1:0]  m_axis_tdata
);

  `FCT_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `FCT_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !m_axis_tvalid, "result shown during reset")
  `FCT_ASSERT(a_stall_full, clk_i, rst_ni, !s_axis_tready |-> m_axis_tvalid, "input stalled with no result pending")
  `FCT_ASSERT(a_latency, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3), "result without request three cycles earlier")

endmodule

bind frustum_cull_test fct_checker u_fct_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench for frustum_cull_test: plane registers, mixed primitive requests, shadow-model checking
module tb;
  import fct_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned PhaseItems    = 60;
  localparam int unsigned ZeroPlaneRows = 8;
  localparam int unsigned DirRows       = 25;
  localparam int unsigned PressurePhase = 2;
  localparam int unsigned PausePhase    = 5;
  localparam int unsigned QuietPhase    = NumPhases - 1;
  localparam longint      AlignScale    = longint'(1) << AlignSh;

  localparam logic [1:0] KindUndef = 2'd3;
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;
  localparam logic [CfgIdxW-1:0] RegOrder [8] = '{RegNear, RegFar, RegTop, RegRight,
                                                  RegBottom, RegLeft, RegSpare6, RegSpare7};
  localparam coord_t NrmPos = 16'sh4000;
  localparam coord_t NrmNeg = 16'shC000;

  typedef enum logic [2:0] {CfgBox, CfgOnes, CfgMin, CfgMax, CfgMixed} cfg_mode_e;
  localparam cfg_mode_e PhaseMode [NumPhases] = '{CfgBox, CfgOnes, CfgBox, CfgMin,
                                                  CfgMax, CfgMixed, CfgMixed, CfgBox};

  typedef struct {
    logic [1:0]         kind;
    coord_t             ax, ay, az;
    coord_t             bx, by, bz;
    logic [RadiusW-1:0] rad;
    bit                 typed;
    bit                 vis;
  } req_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  bit          req_typed;
  bit          req_typed_vis;
  plane_t      shadow_planes [NumPlanes] = '{default: '0};
  plane_t      plane_set [NumPlanes];
  bit          exp_visible_q [$];
  int unsigned req_sent  = 0;
  int unsigned res_got   = 0;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  bit          hold_off_go = 1'b0;
  bit          quiet = 1'b0;
  req_row_t    cull_rows [DirRows];

  frustum_cull_test dut (.*);

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic longint axis_low(coord_t lo, coord_t hi, longint n);
    longint a;
    longint b;
    a = longint'(lo) * n;
    b = longint'(hi) * n;
    return (a < b) ? a : b;
  endfunction

  function automatic bit predict_visible(logic [1:0] kind, in_data_t d);
    plane_t p;
    coord_t px, py, pz;
    longint nx, ny, nz, off, sdist, rad;
    bit vis;
    vis = 1'b1;
    px = d.first_x;
    py = d.first_y;
    pz = d.first_z;
    rad = longint'(d.sphere_radius) * AlignScale;
    for (int k = 0; k < NumPlanes; k++) begin
      p = shadow_planes[k];
      nx = longint'(p.nx);
      ny = longint'(p.ny);
      nz = longint'(p.nz);
      off = longint'(p.offset) * AlignScale;
      if (kind == KindBox) begin
        sdist = axis_low(d.first_x, d.second_x, nx) + axis_low(d.first_y, d.second_y, ny)
              + axis_low(d.first_z, d.second_z, nz) - off;
      end else begin
        sdist = longint'(px) * nx + longint'(py) * ny + longint'(pz) * nz - off;
      end
      if ((kind == KindSphere) ? (sdist > rad) : (sdist > 0)) vis = 1'b0;
    end
    return vis;
  endfunction

  function automatic coord_t rand_coord(bit narrow, int lo, int hi);
    return narrow ? coord_t'(lo + int'($urandom_range(0, hi - lo))) : coord_t'($urandom);
  endfunction

  task automatic box_frustum(coord_t hw, coord_t zn, coord_t zf);
    plane_set[RegNear]   = '{offset: -zn, nz: NrmNeg, ny: '0, nx: '0};
    plane_set[RegFar]    = '{offset: zf, nz: NrmPos, ny: '0, nx: '0};
    plane_set[RegTop]    = '{offset: hw, nz: '0, ny: NrmPos, nx: '0};
    plane_set[RegRight]  = '{offset: hw, nz: '0, ny: '0, nx: NrmPos};
    plane_set[RegBottom] = '{offset: hw, nz: '0, ny: NrmNeg, nx: '0};
    plane_set[RegLeft]   = '{offset: hw, nz: '0, ny: '0, nx: NrmNeg};
  endtask

  task automatic build_planes(cfg_mode_e mode);
    box_frustum(coord_t'(400 + $urandom_range(0, 1600)), coord_t'($urandom_range(0, 200)),
                coord_t'(2000 + $urandom_range(0, 6000)));
    for (int k = 0; k < NumPlanes; k++) begin
      case (mode)
        CfgOnes: plane_set[k] = '1;
        CfgMin:  plane_set[k] = {4{16'h8000}};
        CfgMax:  plane_set[k] = {4{16'h7FFF}};
        CfgMixed: begin
          case ($urandom_range(0, 3))
            0: plane_set[k] = {$urandom, $urandom};
            1: plane_set[k] = '0;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  endtask

  // spare indexes get random data, the block must drop it
  task automatic load_planes();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= RegOrder[i];
      if (RegOrder[i] <= RegLeft) begin
        cfg_data_i <= plane_set[RegOrder[i]];
      end else begin
        cfg_data_i <= {$urandom, $urandom};
      end
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (res_got != req_sent) @(posedge clk_i);
  endtask

  task automatic send_req(logic [1:0] kind, in_data_t d, bit typed, bit vis);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= kind;
    req_typed <= typed;
    req_typed_vis <= vis;
    do @(posedge clk_i); while (!s_axis_tready);
    req_sent++;
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  initial begin : stim
    in_data_t d;
    logic [1:0] kind;
    bit narrow;
    int unsigned sel;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    req_typed <= 1'b0;
    req_typed_vis <= 1'b0;
    rst_ni <= 1'b0;
    cull_rows = '{
      // zero planes: nothing is culled
      '{KindPoint, 0, 0, 0, 0, 0, 0, 0, 1, 1},
      '{KindPoint, 32767, 32767, 32767, -32768, -32768, -32768, 32767, 1, 1},
      '{KindPoint, -32768, -32768, -32768, 32767, 32767, 32767, 0, 1, 1},
      '{KindBox, -32768, -32768, -32768, 32767, 32767, 32767, 0, 1, 1},
      '{KindBox, 32767, 32767, 32767, -32768, -32768, -32768, 32767, 1, 1},
      '{KindSphere, 32767, -32768, 32767, 0, 0, 0, 0, 1, 1},
      '{KindSphere, -32768, 32767, -32768, -1, -1, -1, 32767, 1, 1},
      '{KindUndef, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 15'h5555, 1, 1},
      // box frustum: |x|,|y| <= 100.0, 1.0 <= z <= 500.0
      '{KindPoint, 0, 0, 800, 0, 0, 0, 0, 0, 0},
      '{KindPoint, 1601, 0, 800, 0, 0, 0, 0, 0, 0},
      '{KindPoint, -1601, 0, 800, 0, 0, 0, 0, 0, 0},
      '{KindPoint, 0, 1601, 800, 0, 0, 0, 0, 0, 0},
      '{KindPoint, 0, -1601, 800, 0, 0, 0, 0, 0, 0},
      '{KindPoint, 0, 0, 15, 0, 0, 0, 0, 0, 0},
      '{KindPoint, 0, 0, 8001, 0, 0, 0, 0, 0, 0},
      '{KindPoint, 1600, -1600, 8000, 0, 0, 0, 0, 0, 0},
      '{KindBox, -5000, 0, 100, 5000, 10, 200, 0, 0, 0},
      '{KindBox, 2000, 0, 100, 3000, 10, 200, 0, 0, 0},
      '{KindBox, 200, 200, 900, -200, -200, 100, 0, 0, 0},
      '{KindBox, -2000, -20, 300, -3000, 20, 400, 0, 0, 0},
      '{KindSphere, 1700, 0, 800, 0, 0, 0, 100, 0, 0},
      '{KindSphere, 1700, 0, 800, 0, 0, 0, 99, 0, 0},
      '{KindSphere, -32768, 32767, -32768, 7, 7, 7, 32767, 0, 0},
      '{KindUndef, 0, 0, 800, 5000, 5000, 5000, 0, 0, 0},
      '{KindUndef, 0, 0, -5, 0, 0, 0, 32767, 0, 0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      if (i == ZeroPlaneRows) begin
        drain_results();
        box_frustum(16'sd1600, 16'sd16, 16'sd8000);
        load_planes();
      end
      d = '0;
      d.first_x = cull_rows[i].ax;
      d.first_y = cull_rows[i].ay;
      d.first_z = cull_rows[i].az;
      d.second_x = cull_rows[i].bx;
      d.second_y = cull_rows[i].by;
      d.second_z = cull_rows[i].bz;
      d.sphere_radius = cull_rows[i].rad;
      send_req(cull_rows[i].kind, d, cull_rows[i].typed, cull_rows[i].vis);
      idle_gap();
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      quiet = (ph == QuietPhase);
      build_planes(PhaseMode[ph]);
      load_planes();
      if (ph == PressurePhase) hold_off_go = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == PausePhase && n == PhaseItems / 2) drain_results();
        sel = $urandom_range(0, 9);
        kind = (sel < 4) ? KindPoint : (sel < 7) ? KindBox : (sel < 9) ? KindSphere : KindUndef;
        narrow = ($urandom_range(0, 3) != 0);
        d = '0;
        d.first_x = rand_coord(narrow, -2400, 2400);
        d.first_y = rand_coord(narrow, -2400, 2400);
        d.first_z = rand_coord(narrow, -300, 9000);
        // mostly small boxes, some with swapped corners
        d.second_x = narrow ? d.first_x + rand_coord(1'b1, -900, 900) : rand_coord(1'b0, 0, 0);
        d.second_y = narrow ? d.first_y + rand_coord(1'b1, -900, 900) : rand_coord(1'b0, 0, 0);
        d.second_z = narrow ? d.first_z + rand_coord(1'b1, -900, 900) : rand_coord(1'b0, 0, 0);
        d.sphere_radius = narrow ? RadiusW'($urandom_range(0, 600))
                                 : RadiusW'($urandom_range(0, 32767));
        send_req(kind, d, 1'b0, 1'b0);
        if (ph != PressurePhase && !quiet) idle_gap();
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (exp_visible_q.size() != 0) begin
      err_cnt++;
      $error("visible: %0d expected results never came", exp_visible_q.size());
    end
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin : result_ready
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (64) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_planes <= '{default: '0};
    end else if (cfg_we_i && cfg_idx_i <= RegLeft) begin
      shadow_planes[cfg_idx_i] <= cfg_data_i;
    end
  end

  always @(posedge clk_i) begin : request_watch
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      exp_visible_q.push_back(req_typed ? req_typed_vis
                                        : predict_visible(s_axis_tuser, s_axis_tdata));
    end
  end

  always @(posedge clk_i) begin : result_check
    bit want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_got++;
      if (exp_visible_q.size() == 0) begin
        err_cnt++;
        $error("visible: expected nothing, actual %0d", m_axis_tdata[0]);
      end else begin
        want = exp_visible_q.pop_front();
        if (m_axis_tdata[0] !== want) begin
          err_cnt++;
          $error("visible: expected %0d, actual %0d", want, m_axis_tdata[0]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

endmodule

// File: frustum_cull_test.f
+incdir+rtl
rtl/fct_pkg.sv
rtl/fct_plane.sv
rtl/frustum_cull_test.sv
rtl/fct_checker.sv
tb/sv/tb.sv
